/* design/accel_magnitude_batcher_top_defines.svh */
// Assertion macros for the accelerometer magnitude batcher.
// Included by the top level. Expands to nothing when SYNTHESIS is defined.
`ifndef ACCEL_MAGNITUDE_BATCHER_TOP_DEFINES_SVH
`define ACCEL_MAGNITUDE_BATCHER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define AMB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define AMB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define AMB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define AMB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* design/amb_pkg.sv */
// Package for the accelerometer magnitude batcher.
// Holds widths, register indexes, reset values and shared types; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package amb_pkg;

  localparam int unsigned AxisW    = 16;
  localparam int unsigned MagW     = 8;
  localparam int unsigned BlockW   = 16;
  localparam int unsigned LimitW   = 24;
  localparam int unsigned StoreW   = 25;
  localparam int unsigned SumW     = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] CFG_BLOCK_SIZE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_STORE_LIMIT = 2'd1;

  localparam logic [BlockW-1:0] BLOCK_SIZE_RST  = 16'd512;
  localparam logic [LimitW-1:0] STORE_LIMIT_RST = 24'd65536;

  localparam logic [MagW-1:0] MAG_MAX = 8'd220;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SQ   = 4'b0010,
    S_ROOT = 4'b0100,
    S_DONE = 4'b1000
  } seq_state_e;

  typedef struct packed {
    logic             en;
    logic [AxisW-1:0] op;
  } mul_req_t;

  typedef struct packed {
    logic              flush;
    logic [BlockW-1:0] flush_len;
    logic              xfer;
    logic [StoreW-1:0] xfer_len;
  } book_t;

endpackage

`default_nettype wire

/* design/amb_if.sv */
// Valid/ready channel interfaces for samples in and results out.
// Depends on amb_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface amb_in_if;
  logic                      valid;
  logic                      ready;
  logic [amb_pkg::AxisW-1:0] x_raw;
  logic [amb_pkg::AxisW-1:0] y_raw;
  logic [amb_pkg::AxisW-1:0] z_raw;

  modport source (output valid, x_raw, y_raw, z_raw, input ready);
  modport sink (input valid, x_raw, y_raw, z_raw, output ready);
endinterface

interface amb_out_if;
  logic                       valid;
  logic                       ready;
  logic [amb_pkg::MagW-1:0]   magnitude;
  logic                       flush_before;
  logic [amb_pkg::BlockW-1:0] flush_length;
  logic                       transfer_before;
  logic [amb_pkg::StoreW-1:0] transfer_length;

  modport source (output valid, magnitude, flush_before, flush_length,
                  transfer_before, transfer_length, input ready);
  modport sink (input valid, magnitude, flush_before, flush_length,
                transfer_before, transfer_length, output ready);
endinterface

`default_nettype wire

/* design/amb_mul_unit.sv */
// Shared 16 x 16 squaring unit with a registered 32-bit product.
// Depends on amb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module amb_mul_unit (
  input  wire logic                      clk_i,
  input  wire amb_pkg::mul_req_t         req_i,
  output      logic [amb_pkg::SumW-1:0]  prod_o
);
  import amb_pkg::*;

  logic [SumW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= SumW'(req_i.op) * SumW'(req_i.op);
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

/* design/amb_book.sv */
// Configuration registers and block/store counters of the batcher.
// Latches the flush and transfer flags of each accepted sample. Depends on amb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module amb_book (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [amb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [amb_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          accept_i,
  output      amb_pkg::book_t                book_o
);
  import amb_pkg::*;

  logic [BlockW-1:0] block_size_q;
  logic [LimitW-1:0] store_limit_q;
  logic [BlockW-1:0] block_cnt_q, block_cnt_d;
  logic [StoreW-1:0] store_cnt_q, store_cnt_d;
  book_t             book_q, book_d;
  logic              flush, xfer;
  logic [StoreW-1:0] store_sum;

  always_comb begin
    flush     = block_cnt_q >= block_size_q;
    store_sum = store_cnt_q + StoreW'(block_cnt_q);
    xfer      = flush && (store_sum >= StoreW'(store_limit_q));

    book_d.flush     = flush;
    book_d.flush_len = flush ? block_cnt_q : '0;
    book_d.xfer      = xfer;
    book_d.xfer_len  = xfer ? store_sum : '0;

    block_cnt_d = flush ? BlockW'(1) : block_cnt_q + BlockW'(1);
    if (xfer) begin
      store_cnt_d = '0;
    end else if (flush) begin
      store_cnt_d = store_sum;
    end else begin
      store_cnt_d = store_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q  <= BLOCK_SIZE_RST;
      store_limit_q <= STORE_LIMIT_RST;
      block_cnt_q   <= '0;
      store_cnt_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BLOCK_SIZE:  block_size_q  <= cfg_data_i[BlockW-1:0];
          CFG_STORE_LIMIT: store_limit_q <= cfg_data_i[LimitW-1:0];
          default: ;
        endcase
      end
      if (accept_i) begin
        block_cnt_q <= block_cnt_d;
        store_cnt_q <= store_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      book_q <= book_d;
    end
  end

  assign book_o = book_q;

endmodule

`default_nettype wire

/* design/amb_seq.sv */
// Sequencer for the sum of squares and the bitwise root search.
// Drives the shared squaring unit; depends on amb_pkg and amb_mul_unit.
`timescale 1ns / 1ps
`default_nettype none

module amb_seq (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [amb_pkg::AxisW-1:0]   x_raw_i,
  input  wire logic [amb_pkg::AxisW-1:0]   y_raw_i,
  input  wire logic [amb_pkg::AxisW-1:0]   z_raw_i,
  input  wire logic                        ack_i,
  output      logic                        idle_o,
  output      logic                        done_o,
  output      logic [amb_pkg::MagW-1:0]    mag_o
);
  import amb_pkg::*;

  seq_state_e        state_q, state_d;
  logic [1:0]        ph_q, ph_d;
  logic [2:0]        bit_q, bit_d;
  logic              half_q, half_d;
  logic [MagW-1:0]   k_q, k_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [AxisW-1:0]  ax_q [3];
  logic [MagW-1:0]   cand;
  logic [SumW-1:0]   prod;
  mul_req_t          mul_req;

  function automatic logic [AxisW-1:0] swap_abs(input logic [AxisW-1:0] w);
    logic [AxisW-1:0] s;
    s = {w[7:0], w[15:8]};
    return s[AxisW-1] ? (~s + AxisW'(1)) : s;
  endfunction

  amb_mul_unit u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  always_comb begin
    cand       = k_q | (MagW'(1) << bit_q);
    state_d    = state_q;
    ph_d       = ph_q;
    bit_d      = bit_q;
    half_d     = half_q;
    k_d        = k_q;
    sum_d      = sum_q;
    mul_req.en = 1'b0;
    mul_req.op = {cand, cand};

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_SQ;
          ph_d    = '0;
          sum_d   = '0;
        end
      end
      S_SQ: begin
        case (ph_q)
          2'd0:    mul_req.op = ax_q[0];
          2'd1:    mul_req.op = ax_q[1];
          default: mul_req.op = ax_q[2];
        endcase
        mul_req.en = ph_q != 2'd3;
        if (ph_q != 2'd0) begin
          sum_d = sum_q + prod;
        end
        ph_d = ph_q + 2'd1;
        if (ph_q == 2'd3) begin
          state_d = S_ROOT;
          bit_d   = 3'd7;
          half_d  = 1'b0;
          k_d     = '0;
        end
      end
      S_ROOT: begin
        if (!half_q) begin
          mul_req.en = 1'b1;
          half_d     = 1'b1;
        end else begin
          half_d = 1'b0;
          if (prod <= sum_q) begin
            k_d = cand;
          end
          if (bit_q == 3'd0) begin
            state_d = S_DONE;
          end else begin
            bit_d = bit_q - 3'd1;
          end
        end
      end
      S_DONE: begin
        if (ack_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q    <= '0;
      bit_q   <= '0;
      half_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      bit_q   <= bit_d;
      half_q  <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    sum_q <= sum_d;
    if (state_q == S_IDLE && start_i) begin
      ax_q[0] <= swap_abs(x_raw_i);
      ax_q[1] <= swap_abs(y_raw_i);
      ax_q[2] <= swap_abs(z_raw_i);
    end
  end

  assign idle_o = state_q == S_IDLE;
  assign done_o = state_q == S_DONE;
  assign mag_o  = k_q;

endmodule

`default_nettype wire

/* design/accel_magnitude_batcher_top.sv */
// An accepted request passes through the sequencer states S_SQ, S_ROOT and S_DONE before
// its result is loaded into the output register. A new request is taken only once the
// sequencer is idle again. The shared squaring unit serves three squares and then eight
// trials in the root search. A finished result waits in the output register while the
// next request is taken. Reset is asynchronous and active low; counters clear and
// configuration registers take their reset values at once, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "accel_magnitude_batcher_top_defines.svh"

module accel_magnitude_batcher_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [amb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [amb_pkg::CfgDataW-1:0] cfg_data_i,
  amb_in_if.sink                            in_i,
  amb_out_if.source                         out_o
);
  import amb_pkg::*;

  logic            accept;
  logic            seq_idle, seq_done, load;
  logic [MagW-1:0] seq_mag;
  book_t           book;
  logic            out_valid_q, out_valid_d;
  logic [MagW-1:0] mag_q;
  book_t           book_out_q;

  assign in_i.ready = seq_idle;
  assign accept     = in_i.valid && seq_idle;

  amb_book u_book (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .book_o     (book)
  );

  amb_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .x_raw_i (in_i.x_raw),
    .y_raw_i (in_i.y_raw),
    .z_raw_i (in_i.z_raw),
    .ack_i   (load),
    .idle_o  (seq_idle),
    .done_o  (seq_done),
    .mag_o   (seq_mag)
  );

  assign load = seq_done && (!out_valid_q || out_o.ready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mag_q      <= seq_mag;
      book_out_q <= book;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.magnitude       = mag_q;
  assign out_o.flush_before    = book_out_q.flush;
  assign out_o.flush_length    = book_out_q.flush_len;
  assign out_o.transfer_before = book_out_q.xfer;
  assign out_o.transfer_length = book_out_q.xfer_len;

  `AMB_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, accept, !in_i.ready, "ready after request")
  `AMB_ASSERT_IMPL(a_mag_range, clk_i, rst_ni, out_o.valid, out_o.magnitude <= MAG_MAX, "magnitude too large")
  `AMB_ASSERT_IMPL(a_xfer_needs_flush, clk_i, rst_ni, out_o.valid && out_o.transfer_before, out_o.flush_before, "transfer without flush")
  `AMB_ASSERT_IMPL(a_flush_len_zero, clk_i, rst_ni, out_o.valid && !out_o.flush_before, out_o.flush_length == '0, "flush length without flush")

endmodule

`default_nettype wire

/* bench/accel_magnitude_batcher_top_tb.sv */
// Self-checking bench for accel_magnitude_batcher_top: sends accelerometer requests and checks
// each result against an in-bench prediction of magnitude, flush and transfer bookkeeping.
// Depends on amb_pkg, amb_in_if and amb_out_if from the design folder.
`timescale 1ns / 1ps

module accel_magnitude_batcher_top_tb;
  import amb_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 2'd3;
  localparam longint unsigned DivisorSq = 66049;
  localparam int unsigned DrainCycles = 30;
  localparam int unsigned PressureCycles = 400;
  localparam int unsigned MaxPrinted = 40;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [MagW-1:0] magnitude;
    book_t           book;
  } mag_result_t;

  class magnitude_scoreboard;
    logic [BlockW-1:0] block_size;
    logic [LimitW-1:0] store_limit;
    logic [BlockW-1:0] block_count;
    logic [StoreW-1:0] store_count;
    mag_result_t       expected_q[$];
    int unsigned       errors;

    function new();
      block_size  = BLOCK_SIZE_RST;
      store_limit = STORE_LIMIT_RST;
      block_count = '0;
      store_count = '0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_BLOCK_SIZE: begin
          block_size = data[BlockW-1:0];
        end
        CFG_STORE_LIMIT: begin
          store_limit = data[LimitW-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function longint unsigned axis_square(logic [AxisW-1:0] raw);
      logic [AxisW-1:0] swapped;
      longint           v;
      swapped = {raw[7:0], raw[15:8]};
      v = longint'($signed(swapped));
      return longint'(v * v);
    endfunction

    function logic [MagW-1:0] scaled_length(longint unsigned sum_sq);
      longint unsigned k;
      k = 255;
      while (k > 0 && DivisorSq * k * k > sum_sq) begin
        k--;
      end
      return k[MagW-1:0];
    endfunction

    function void note_sample(logic [AxisW-1:0] x, logic [AxisW-1:0] y, logic [AxisW-1:0] z);
      mag_result_t     r;
      longint unsigned sum_sq;
      r = '0;
      if (block_count >= block_size) begin
        r.book.flush     = 1'b1;
        r.book.flush_len = block_count;
        store_count      = store_count + block_count;
        block_count      = '0;
        if (store_count >= store_limit) begin
          r.book.xfer     = 1'b1;
          r.book.xfer_len = store_count;
          store_count     = '0;
        end
      end
      sum_sq = axis_square(x) + axis_square(y) + axis_square(z);
      r.magnitude = scaled_length(sum_sq);
      block_count = block_count + 1'b1;
      expected_q.push_back(r);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      if (errors < MaxPrinted) begin
        $display("mismatch at %0t: %s", $time, msg);
      end
      errors++;
    endtask

    task check_result(mag_result_t got);
      mag_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing expected, magnitude %0d", got.magnitude));
        return;
      end
      want = expected_q.pop_front();
      if (got.magnitude !== want.magnitude) begin
        report($sformatf("magnitude got %0d want %0d", got.magnitude, want.magnitude));
      end
      if (got.book.flush !== want.book.flush) begin
        report($sformatf("flush_before got %0b want %0b", got.book.flush, want.book.flush));
      end
      if (got.book.flush_len !== want.book.flush_len) begin
        report($sformatf("flush_length got %0d want %0d",
                         got.book.flush_len, want.book.flush_len));
      end
      if (got.book.xfer !== want.book.xfer) begin
        report($sformatf("transfer_before got %0b want %0b", got.book.xfer, want.book.xfer));
      end
      if (got.book.xfer_len !== want.book.xfer_len) begin
        report($sformatf("transfer_length got %0d want %0d",
                         got.book.xfer_len, want.book.xfer_len));
      end
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  amb_in_if  in_if ();
  amb_out_if out_if ();

  magnitude_scoreboard sb = new();

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_left;

  accel_magnitude_batcher_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_SEND: begin
        send_idle_pct  = 68;
        recv_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_idle_pct  = 0;
        recv_stall_pct = 68;
      end
      IDLE_BOTH: begin
        send_idle_pct  = 13;
        recv_stall_pct = 13;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(logic [CfgDataW-1:0] bsize, logic [CfgDataW-1:0] slimit);
    cfg_write(CFG_BLOCK_SIZE, bsize);
    cfg_write(CFG_STORE_LIMIT, slimit);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_sample(logic [AxisW-1:0] x, logic [AxisW-1:0] y, logic [AxisW-1:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.x_raw <= x;
    in_if.y_raw <= y;
    in_if.z_raw <= z;
    @(posedge clk_i);
    while (!in_if.ready) begin
      @(posedge clk_i);
    end
    sb.note_sample(x, y, z);
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (sb.pending() != 0);
  endtask

  // Words are in sensor order, so values near the magnitude steps are built and then swapped.
  function automatic logic [AxisW-1:0] rand_word();
    int               v;
    logic [AxisW-1:0] w;
    case ($urandom_range(7))
      0: w = 16'h0080;
      1: w = 16'hFF7F;
      2: w = ($urandom_range(1) == 0) ? 16'h0000 : 16'hFFFF;
      3: begin
        v = 257 * $urandom_range(127) - $urandom_range(1);
        if ($urandom_range(1) == 1) begin
          v = -v;
        end
        w = {v[7:0], v[15:8]};
      end
      default: w = AxisW'($urandom());
    endcase
    return w;
  endfunction

  task automatic send_random(int unsigned n);
    repeat (n) begin
      send_sample(rand_word(), rand_word(), rand_word());
    end
  endtask

  initial begin
    mag_result_t got;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        got.magnitude      = out_if.magnitude;
        got.book.flush     = out_if.flush_before;
        got.book.flush_len = out_if.flush_length;
        got.book.xfer      = out_if.transfer_before;
        got.book.xfer_len  = out_if.transfer_length;
        sb.check_result(got);
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_data_i  <= '0;
    in_if.valid <= 1'b0;
    in_if.x_raw <= '0;
    in_if.y_raw <= '0;
    in_if.z_raw <= '0;
    hold_left = 0;
    set_idling(IDLE_NONE);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Field extremes and magnitude steps under the reset configuration.
    send_sample(16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h0080, 16'h0080, 16'h0080);
    send_sample(16'hFF7F, 16'hFF7F, 16'hFF7F);
    send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(16'h0101, 16'h0000, 16'h0000);
    send_sample(16'h0001, 16'h0000, 16'h0000);
    send_sample(16'h6464, 16'h0000, 16'h0000);
    send_sample(16'h6364, 16'h0000, 16'h0000);
    send_sample(16'h0080, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h9C9B, 16'h0000);
    send_sample(16'h0000, 16'h0000, 16'h7F80);
    send_sample(16'h5555, 16'hAAAA, 16'h0F0F);
    send_sample(16'hAAAA, 16'h5555, 16'hF0F0);
    send_sample(16'h8000, 16'h0100, 16'h7FFF);
    wait_drain();

    // Zero block size and zero store limit; the upper data bits must be dropped.
    configure(24'hFF0000, 24'h000000);
    send_sample(16'h1234, 16'h5678, 16'h9ABC);
    send_sample(16'h0080, 16'hFF7F, 16'h0000);
    send_sample(16'hFFFF, 16'h0001, 16'h0101);
    wait_drain();
    configure(24'h12FFFF, 24'hFFFFFF);
    send_sample(16'h0000, 16'h0080, 16'h0000);
    send_sample(16'h0F0F, 16'hF0F0, 16'h00FF);
    wait_drain();

    set_idling(IDLE_NONE);
    configure(24'd1, 24'd3);
    send_random(250);
    wait_drain();

    set_idling(IDLE_SEND);
    cfg_write(CFG_SPARE_A, '1);
    cfg_write(CFG_SPARE_B, CfgDataW'($urandom()));
    configure(24'd0, 24'd0);
    send_random(150);
    wait_drain();

    set_idling(IDLE_RECV);
    configure(24'd5, 24'hFFFFFF);
    send_random(200);
    wait_drain();

    // Lower limits well under the counts that have built up.
    set_idling(IDLE_BOTH);
    configure(24'd3, 24'd1);
    send_random(150);
    wait_drain();

    set_idling(IDLE_SEND);
    configure(24'h00FFFF, 24'd40);
    send_random(150);
    wait_drain();

    // The receiver holds off while requests keep coming, then the sender waits for all results.
    set_idling(IDLE_NONE);
    configure(24'd7, 24'd20);
    hold_left = PressureCycles;
    send_random(100);
    wait_drain();
    send_random(100);
    wait_drain();

    repeat (4) begin
      set_idling(idle_mode_e'($urandom_range(3)));
      configure(CfgDataW'($urandom_range(16, 1)), CfgDataW'($urandom_range(60, 1)));
      send_random(150);
      wait_drain();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* accel_magnitude_batcher_top.f */
+incdir+design
design/amb_pkg.sv
design/amb_if.sv
design/amb_mul_unit.sv
design/amb_book.sv
design/amb_seq.sv
design/accel_magnitude_batcher_top.sv
bench/accel_magnitude_batcher_top_tb.sv
